### rtl/slecf_pkg.sv
package slecf_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 9;
    localparam int LIM_W  = 11;
    localparam int POS_W  = 13;
    localparam int KIND_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WIN = 6;

    localparam logic [KIND_W-1:0] KIND_CROSS    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_THR  = 3'd4;

    localparam logic [POS_W-1:0] POS_STATUS = '1;
    localparam logic [POS_W-1:0] POS_EARLY  = 13'd2;

    localparam logic [PIX_W-1:0] THR_RESET = 8'd128;
    localparam logic [PIX_W-1:0] THR_MAX   = 8'd255;

    // One queue entry holds everything a column produces: up to three results.
    typedef struct packed {
        logic              held;
        logic              xing;
        logic [POS_W-1:0]  cross_pos;
        logic              status;
        logic [KIND_W-1:0] status_kind;
    } cmd_t;

endpackage

### rtl/slecf_front.sv
module slecf_front
    import slecf_pkg::*;
#(
    parameter int LINE_MAX = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PIX_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2*PIX_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    localparam int CNT_W  = $clog2(LINE_MAX + 1);
    localparam int CALC_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [LIM_W-1:0] lim_reg;
    logic             thr_ok_reg;

    logic [SUM_W-1:0] prev_reg,  prev_next;
    logic [PIX_W-1:0] win_reg  [WIN];
    logic [PIX_W-1:0] win_next [WIN];
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             found_reg, found_next;
    logic             held_reg,  held_next;

    logic              accept;
    logic              in_range;
    logic [SUM_W-1:0]  colsum;
    logic [SUM_W:0]    pairsum;
    logic [PIX_W-1:0]  sample;
    logic [LIM_W-1:0]  mid;
    logic [LIM_W-1:0]  s1;
    logic [LIM_W-1:0]  s2;
    logic              xing;
    logic [CNT_W-1:0]  cnt_after;
    logic [CALC_W-1:0] pos_calc;
    cmd_t              cmd;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // The threshold is kept as its limit 5 * threshold, formed at the write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg    <= LIM_W'(THR_RESET) + (LIM_W'(THR_RESET) << 2);
            thr_ok_reg <= 1'b1;
        end else if (cfg_valid) begin
            lim_reg    <= LIM_W'(cfg_data) + (LIM_W'(cfg_data) << 2);
            thr_ok_reg <= (cfg_data != '0) && (cfg_data != THR_MAX);
        end
    end

    assign in_range = cnt_reg < CNT_W'(LINE_MAX);
    assign colsum   = SUM_W'(s_tdata[PIX_W-1:0]) + SUM_W'(s_tdata[2*PIX_W-1:PIX_W]);
    assign pairsum  = (SUM_W + 1)'(prev_reg) + (SUM_W + 1)'(colsum);
    assign sample   = pairsum[SUM_W:2];

    // After the shift, window slots 1..4 hold the old slots 2..5.
    assign mid   = LIM_W'(win_reg[2]) + LIM_W'(win_reg[3])
                 + LIM_W'(win_reg[4]) + LIM_W'(win_reg[5]);
    assign s1    = mid + LIM_W'(win_reg[1]);
    assign s2    = mid + LIM_W'(sample);
    assign xing  = (s1 > lim_reg) != (s2 > lim_reg);

    assign pos_calc = CALC_W'(cnt_reg) - CALC_W'(9);

    always_comb begin
        prev_next  = prev_reg;
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        held_next  = held_reg;
        cnt_after  = cnt_reg;
        cmd        = '0;
        cmd.cross_pos   = pos_calc[POS_W-1:0];
        cmd.status_kind = KIND_NONE;

        if (accept) begin
            if (in_range) begin
                if (cnt_reg >= CNT_W'(6)) begin
                    for (int i = 0; i < WIN - 1; i++) begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[WIN-1] = sample;
                    if (!thr_ok_reg) begin
                        held_next = 1'b0;
                    end else if (cnt_reg == CNT_W'(11)) begin
                        held_next = xing;
                    end else if (cnt_reg > CNT_W'(11)) begin
                        cmd.held   = held_reg;
                        cmd.xing   = xing;
                        held_next  = 1'b0;
                        found_next = found_reg || held_reg || xing;
                    end
                end
                prev_next = colsum;
                cnt_after = cnt_reg + CNT_W'(1);
                cnt_next  = cnt_after;
            end

            if (s_tlast) begin
                cmd.status = 1'b1;
                if (!thr_ok_reg) begin
                    cmd.status_kind = KIND_BAD_THR;
                end else if (cnt_after <= CNT_W'(12)) begin
                    cmd.status_kind = KIND_SHORT;
                end else if (found_next) begin
                    cmd.status_kind = KIND_DONE;
                end else begin
                    cmd.status_kind = KIND_NONE;
                end
                cnt_next   = '0;
                found_next = 1'b0;
                held_next  = 1'b0;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.held || cmd.xing || cmd.status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            held_reg  <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            held_reg  <= held_next;
        end
    end

    // The window and previous sum are refilled before every use in a line.
    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        win_reg  <= win_next;
    end

endmodule

### rtl/slecf_queue.sv
module slecf_queue
    import slecf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg,  wr_next;
    logic [QPTR_W-1:0] rd_reg,  rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign head  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/slecf_back.sv
module slecf_back
    import slecf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [KIND_W-1:0] m_tuser,
    output logic              m_tlast
);

    // done_reg marks the results of the head entry already sent:
    // bit 0 the held crossing, bit 1 the crossing, bit 2 the status.
    logic [2:0]        done_reg,  done_next;
    logic              valid_reg, valid_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [KIND_W-1:0] kind_reg,  kind_next;
    logic              last_reg,  last_next;

    logic       load;
    logic [2:0] pend;
    logic [2:0] pick;

    assign load = !valid_reg || m_tready;
    assign pend = empty ? 3'b000 : ({head.status, head.xing, head.held} & ~done_reg);
    assign pick = pend & (~pend + 3'd1);

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg && !m_tready;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (load && (pend != 3'b000)) begin
            valid_next = 1'b1;
            if (pick[0]) begin
                pos_next  = POS_EARLY;
                kind_next = KIND_CROSS;
                last_next = 1'b0;
            end else if (pick[1]) begin
                pos_next  = head.cross_pos;
                kind_next = KIND_CROSS;
                last_next = 1'b0;
            end else begin
                pos_next  = POS_STATUS;
                kind_next = head.status_kind;
                last_next = 1'b1;
            end
            if ((pend & ~pick) == 3'b000) begin
                pop       = 1'b1;
                done_next = 3'b000;
            end else begin
                done_next = done_reg | pick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(16 - POS_W){1'b0}}, pos_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/scan_line_edge_crossing_finder_top.sv
// Channel  | Direction | Word
// ---------+-----------+----------------------------------------------------------
// cfg_     | in        | cfg_data[7:0] threshold
// s_       | in        | tdata[7:0] top_pixel, tdata[15:8] bottom_pixel, tlast line_end
// m_       | out       | tdata[12:0] position, tuser[2:0] kind, tlast last
//
// One column word is taken per clock while the queue is not full; a column that
// yields k results (0 to 3) sends them one by one from the single output register,
// so the sustained rate is one word per cycle while columns average at most one result.
// A four-entry queue between the column front end and the result sequencer
// absorbs bursts; s_tready drops only when that queue is full.
// Reset (aresetn low, synchronous) sets the threshold to 128 and starts a new line.
module scan_line_edge_crossing_finder_top
    import slecf_pkg::*;
#(
    parameter int LINE_MAX = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PIX_W-1:0]  cfg_data,     // threshold
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2*PIX_W-1:0] s_tdata,     // [7:0] top_pixel, [15:8] bottom_pixel
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,      // [12:0] position, [15:13] zero
    output logic [KIND_W-1:0] m_tuser,      // [2:0] kind
    output logic              m_tlast
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    slecf_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    slecf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    slecf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
